// ===== rtl/core/binary_frame_difference_detector_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame difference detector core
// Shared property wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef BINARY_FRAME_DIFFERENCE_DETECTOR_CORE_ASSERT_SVH
`define BINARY_FRAME_DIFFERENCE_DETECTOR_CORE_ASSERT_SVH

// checked only while out of reset
`define BFDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bfdd assertion failed");

// checked also during reset
`define BFDD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("bfdd reset assertion failed");

`endif

// ===== rtl/core/bfdd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdd_pkg
// Types and constants shared by the frame difference detector modules.
// ----------------------------------------------------------------------------
package bfdd_pkg;

    // frame geometry
    localparam int FRAME_PIXELS = 65536;
    localparam int PIX_ADDR_W   = $clog2(FRAME_PIXELS);

    // gray conversion weights, scaled by 65536
    localparam logic [23:0] WEIGHT_RED   = 24'd19588;
    localparam logic [23:0] WEIGHT_GREEN = 24'd38470;
    localparam logic [23:0] WEIGHT_BLUE  = 24'd7471;
    localparam int          PROD_W       = 24;

    // cost of one mismatching pixel
    localparam logic [32:0] MISMATCH_COST = 33'd255;

    // configuration register defaults and indexes
    localparam logic [7:0]  THR_RESET      = 8'd60;
    localparam logic [31:0] LIMIT_RESET    = 32'd200000;
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_BIN_THR    = 1'b0;
    localparam logic        REG_DIFF_LIMIT = 1'b1;

    // front to back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // one classified pixel request
    typedef struct packed {
        logic                  pix_set;
        logic [PIX_ADDR_W-1:0] addr;
        logic                  last;
    } t_pix;

endpackage

// ===== rtl/core/bfdd_ram.sv =====
// ----------------------------------------------------------------------------
// bfdd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfdd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bfdd_front.sv =====
// ----------------------------------------------------------------------------
// bfdd_front
// Accepts RGB pixels, converts to gray, thresholds and tags each pixel
// with its address in the frame.
// ----------------------------------------------------------------------------
module bfdd_front
    import bfdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_end_of_frame,
    input  logic [7:0] i_bin_thr,
    input  logic       i_q_full,
    output logic       o_push,
    output t_pix       o_pix
);

    logic                  r_p_valid;
    logic [PROD_W-1:0]     r_prod_r;
    logic [PROD_W-1:0]     r_prod_g;
    logic [PROD_W-1:0]     r_prod_b;
    logic                  r_last;
    logic [PIX_ADDR_W-1:0] r_addr;
    logic [PIX_ADDR_W-1:0] r_addr_cnt;
    logic [PIX_ADDR_W-1:0] n_addr_cnt;
    logic                  accept;
    logic [PROD_W:0]       gray_sum;
    logic [7:0]            gray;

    assign o_stall = r_p_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_p_valid && !i_q_full;

    // next pixel address: wraps at frame size, restarts after frame end
    always_comb begin
        if (i_end_of_frame || r_addr_cnt == PIX_ADDR_W'(FRAME_PIXELS - 1)) begin
            n_addr_cnt = '0;
        end else begin
            n_addr_cnt = r_addr_cnt + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid  <= 1'b0;
            r_addr_cnt <= '0;
        end else begin
            if (accept) begin
                r_p_valid  <= 1'b1;
                r_addr_cnt <= n_addr_cnt;
            end else if (o_push) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    // weighted channel products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_r <= PROD_W'(i_red)   * WEIGHT_RED;
            r_prod_g <= PROD_W'(i_green) * WEIGHT_GREEN;
            r_prod_b <= PROD_W'(i_blue)  * WEIGHT_BLUE;
            r_last   <= i_end_of_frame;
            r_addr   <= r_addr_cnt;
        end
    end

    // sum, truncate, threshold
    assign gray_sum = {1'b0, r_prod_r} + {1'b0, r_prod_g} + {1'b0, r_prod_b};
    assign gray     = gray_sum[23:16];

    assign o_pix.pix_set = gray > i_bin_thr;
    assign o_pix.addr    = r_addr;
    assign o_pix.last    = r_last;

endmodule

// ===== rtl/core/bfdd_fifo.sv =====
// ----------------------------------------------------------------------------
// bfdd_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bfdd_fifo
    import bfdd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pix,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_pix o_pix
);

    t_pix               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = r_count == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_pix   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pix;
        end
    end

endmodule

// ===== rtl/core/bfdd_back.sv =====
// ----------------------------------------------------------------------------
// bfdd_back
// Reads the reference frame, counts mismatches, stores the current frame
// and reports one result at each frame end.
// ----------------------------------------------------------------------------
module bfdd_back
    import bfdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_pix        i_pix,
    output logic        o_pop,
    input  logic [31:0] i_diff_limit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_detected,
    output logic [31:0] o_difference_sum,
    output logic        o_reference_taken
);

    t_pix        r_s1;
    logic        r_s1_valid;
    logic        r_fwd_hit;
    logic        r_fwd_store;
    logic        r_fwd_bit;
    logic        r_sel;
    logic        r_ref_valid;
    logic [31:0] r_sum;
    logic        r_exceeded;
    logic        r_out_valid;
    logic        r_out_detected;
    logic [31:0] r_out_sum;
    logic        r_out_taken;

    logic        out_free;
    logic        s1_adv;
    logic        rd_a;
    logic        rd_b;
    logic        ref_bit;
    logic        compare;
    logic [32:0] sum_inc;
    logic [31:0] sum_new;
    logic        exc_new;

    // handshake between stage and result register
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && (!r_s1.last || out_free);
    assign o_pop    = i_q_valid && (!r_s1_valid || s1_adv);

    // ping-pong stores: sel=0 means store a holds the reference
    bfdd_ram #(.WIDTH(1), .DEPTH(FRAME_PIXELS)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (s1_adv && r_sel),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.pix_set),
        .i_re    (o_pop),
        .i_raddr (i_pix.addr),
        .o_rdata (rd_a)
    );

    bfdd_ram #(.WIDTH(1), .DEPTH(FRAME_PIXELS)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (s1_adv && !r_sel),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.pix_set),
        .i_re    (o_pop),
        .i_raddr (i_pix.addr),
        .o_rdata (rd_b)
    );

    // reference bit, with forwarding of a write that raced the read
    always_comb begin
        if (r_fwd_hit && r_fwd_store == r_sel) begin
            ref_bit = r_fwd_bit;
        end else begin
            ref_bit = r_sel ? rd_b : rd_a;
        end
    end

    // saturating accumulate and limit check
    assign compare = r_ref_valid && !r_exceeded;
    assign sum_inc = {1'b0, r_sum} + MISMATCH_COST;

    always_comb begin
        sum_new = r_sum;
        if (compare && (ref_bit != r_s1.pix_set)) begin
            sum_new = sum_inc[32] ? '1 : sum_inc[31:0];
        end
    end

    assign exc_new = r_exceeded || (compare && (sum_new > i_diff_limit));

    // stage register and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (r_s1.addr == i_pix.addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1        <= i_pix;
            r_fwd_store <= !r_sel;
            r_fwd_bit   <= r_s1.pix_set;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_ref_valid <= 1'b0;
            r_sum       <= '0;
            r_exceeded  <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1.last) begin
                r_sum      <= '0;
                r_exceeded <= 1'b0;
                if (!r_ref_valid) begin
                    r_ref_valid <= 1'b1;
                    r_sel       <= !r_sel;
                end else if (!exc_new) begin
                    r_sel <= !r_sel;
                end
            end else begin
                r_sum      <= sum_new;
                r_exceeded <= exc_new;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.last) begin
            r_out_detected <= r_ref_valid && exc_new;
            r_out_sum      <= r_ref_valid ? sum_new : '0;
            r_out_taken    <= !r_ref_valid;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_detected        = r_out_detected;
    assign o_difference_sum  = r_out_sum;
    assign o_reference_taken = r_out_taken;

endmodule

// ===== rtl/core/binary_frame_difference_detector_core.sv =====
// ----------------------------------------------------------------------------
// binary_frame_difference_detector_core
// Binary frame differencing motion detector with ping-pong reference stores.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle, sustained while o_stall stays low.
// Result path: the last pixel of a frame passes the product register, the queue,
//   the stage and reference read registers, then the result register.
// Reset: synchronous, active low; clears control state and restores register
//   defaults. Frame stores are not cleared; the first frame becomes the reference.
`include "binary_frame_difference_detector_core_assert.svh"

module binary_frame_difference_detector_core
    import bfdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic                  i_end_of_frame,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_detected,
    output logic [31:0]           o_difference_sum,
    output logic                  o_reference_taken,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0]  r_bin_thr;
    logic [31:0] r_diff_limit;
    logic        cfg_wr;
    logic        cfg_idx;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_pix        front_pix;
    t_pix        q_pix;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_thr    <= THR_RESET;
            r_diff_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_BIN_THR:    r_bin_thr    <= pwdata[7:0];
                REG_DIFF_LIMIT: r_diff_limit <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BIN_THR:    prdata = {24'd0, r_bin_thr};
            REG_DIFF_LIMIT: prdata = r_diff_limit;
            default:        prdata = '0;
        endcase
    end

    // pixel classification
    bfdd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_end_of_frame (i_end_of_frame),
        .i_bin_thr      (r_bin_thr),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_pix          (front_pix)
    );

    // decoupling queue
    bfdd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pix   (front_pix),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_pix   (q_pix)
    );

    // compare, accumulate, report
    bfdd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_pix             (q_pix),
        .o_pop             (q_pop),
        .i_diff_limit      (r_diff_limit),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_detected        (o_detected),
        .o_difference_sum  (o_difference_sum),
        .o_reference_taken (o_reference_taken)
    );

    // checks
    `BFDD_ASSERT(a_no_q_overflow, !(q_push && q_full))
    `BFDD_ASSERT(a_no_q_underflow, q_pop |-> q_valid)
    `BFDD_ASSERT(a_taken_is_clean, (o_valid && o_reference_taken) |-> (!o_detected && o_difference_sum == 32'd0))
    `BFDD_ASSERT(a_detect_has_sum, (o_valid && o_detected) |-> (o_difference_sum != 32'd0))
    `BFDD_ASSERT_ALWAYS(a_reset_clears_out, $past(!i_rst_n) |-> !o_valid)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: frame difference detector testbench
// Drives pixel requests through the valid/stall channel and checks each frame
// report against a bit-exact scoreboard model of the gray conversion,
// ping-pong reference stores and frozen mismatch sum. A short directed list
// covers extremes and the first-frame case. Random phases then vary
// thresholds, limits, frame shapes, idling and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import bfdd_pkg::*;

    localparam int          CLK_HALF      = 4;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          QUIET_CYCLES  = 8;
    localparam int          RANDOM_PIXELS = 1750;
    localparam int          HOLD_CYCLES   = 400;
    localparam int unsigned GRAY_W_RED    = 19588;
    localparam int unsigned GRAY_W_GREEN  = 38470;
    localparam int unsigned GRAY_W_BLUE   = 7471;
    localparam logic [31:0] MISS_COST     = 32'd255;
    localparam logic [7:0]  DEF_THR       = 8'd60;
    localparam logic [31:0] DEF_LIMIT     = 32'd200000;

    typedef struct packed {
        logic        detected;
        logic [31:0] diff_sum;
        logic        taken;
    } t_frame_report;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        logic          cfg_sel;
        logic [31:0]   cfg_value;
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
        logic          eof;
        logic          typed;
        t_frame_report report;
    } t_walk_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_red;
    logic [7:0]            i_green;
    logic [7:0]            i_blue;
    logic                  i_end_of_frame;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_detected;
    logic [31:0]           o_difference_sum;
    logic                  o_reference_taken;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // scoreboard model state
    logic [7:0]            model_thr;
    logic [31:0]           model_limit;
    bit                    store_bits [0:1][0:FRAME_PIXELS-1];
    int                    store_extent [0:1];
    logic                  ref_side;
    logic                  ref_ready;
    logic [PIX_ADDR_W-1:0] pix_addr;
    logic [31:0]           run_sum;
    logic                  over_limit;

    t_frame_report pending_reports [$];
    int            fail_count    = 0;
    int            tx_idle_pct   = 28;
    int            rx_idle_pct   = 28;
    int            rx_hold_left  = 0;
    int            hold_requests = 0;
    int            hold_seen     = 0;
    int unsigned   cycle_count   = 0;

    binary_frame_difference_detector_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_end_of_frame    (i_end_of_frame),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_detected        (o_detected),
        .o_difference_sum  (o_difference_sum),
        .o_reference_taken (o_reference_taken),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_seen != hold_requests) begin
                hold_seen    = hold_requests;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                i_stall <= 1'b1;
                rx_hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // compare each accepted report with the oldest expectation
    always @(posedge i_clk) begin : report_check
        t_frame_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected report, expected none, actual det %0d sum %0d taken %0d",
                         $time, o_detected, o_difference_sum, o_reference_taken);
            end else begin
                want = pending_reports.pop_front();
                if (o_detected !== want.detected) begin
                    fail_count++;
                    $display("%0t: detected expected %0d actual %0d",
                             $time, want.detected, o_detected);
                end
                if (o_difference_sum !== want.diff_sum) begin
                    fail_count++;
                    $display("%0t: difference_sum expected %0d actual %0d",
                             $time, want.diff_sum, o_difference_sum);
                end
                if (o_reference_taken !== want.taken) begin
                    fail_count++;
                    $display("%0t: reference_taken expected %0d actual %0d",
                             $time, want.taken, o_reference_taken);
                end
            end
        end
    end

    function automatic logic [7:0] gray_level(input logic [7:0] r, g, b);
        int unsigned wsum;
        wsum = GRAY_W_RED * r + GRAY_W_GREEN * g + GRAY_W_BLUE * b;
        return 8'(wsum >> 16);
    endfunction

    // classify one pixel, compare with the reference, update the frame sum
    task automatic score_pixel(input logic [7:0] r, g, b, input logic eof,
                               output logic has_report, output t_frame_report report);
        logic pix_set;
        logic cur_side;
        pix_set    = gray_level(r, g, b) > model_thr;
        cur_side   = ~ref_side;
        has_report = 1'b0;
        report     = '0;
        if (ref_ready && !over_limit) begin
            if (store_bits[ref_side][pix_addr] != pix_set)
                run_sum = (run_sum > 32'hFFFF_FFFF - MISS_COST) ? 32'hFFFF_FFFF
                                                               : run_sum + MISS_COST;
            if (run_sum > model_limit)
                over_limit = 1'b1;
        end
        store_bits[cur_side][pix_addr] = pix_set;
        if (int'(pix_addr) + 1 > store_extent[cur_side])
            store_extent[cur_side] = int'(pix_addr) + 1;
        pix_addr = (int'(pix_addr) == FRAME_PIXELS - 1) ? '0 : pix_addr + 1'b1;
        if (eof) begin
            has_report = 1'b1;
            if (!ref_ready) begin
                report    = t_frame_report'{1'b0, 32'd0, 1'b1};
                ref_ready = 1'b1;
                ref_side  = ~ref_side;
            end else begin
                report = t_frame_report'{over_limit, run_sum, 1'b0};
                if (!over_limit)
                    ref_side = ~ref_side;
            end
            pix_addr   = '0;
            run_sum    = '0;
            over_limit = 1'b0;
        end
    endtask

    // offer one pixel request and wait for it to be taken
    task automatic push_pixel(input logic [7:0] r, g, b, input logic eof,
                              input logic typed, input t_frame_report typed_report);
        logic          has_report;
        t_frame_report report;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (o_stall);
        score_pixel(r, g, b, eof, has_report, report);
        if (has_report)
            pending_reports.push_back(typed ? typed_report : report);
    endtask

    // random pixel whose binary value is want, where the threshold allows it
    task automatic pick_pixel(input logic want, output logic [7:0] r, g, b);
        int tries;
        for (tries = 0; tries < 6; tries++) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            if ((gray_level(r, g, b) > model_thr) == want)
                return;
        end
        r = want ? 8'hFF : 8'h00;
        g = r;
        b = r;
    endtask

    // register write while idle, then read it back
    task automatic write_register(input logic cfg_sel, input logic [31:0] value);
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           want;
        addr = CFG_ADDR_W'(4 * int'(cfg_sel));
        want = (cfg_sel == REG_BIN_THR) ? {24'd0, value[7:0]} : value;
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (cfg_sel == REG_BIN_THR)
            model_thr = value[7:0];
        else
            model_limit = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            fail_count++;
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, cfg_sel, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_walk_row pix_row(input logic [7:0] r, g, b, input logic eof);
        t_walk_row row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        row.eof   = eof;
        return row;
    endfunction

    function automatic t_walk_row report_row(input logic [7:0] r, g, b,
                                             input t_frame_report report);
        t_walk_row row;
        row        = pix_row(r, g, b, 1'b1);
        row.typed  = 1'b1;
        row.report = report;
        return row;
    endfunction

    function automatic t_walk_row cfg_row(input logic cfg_sel, input logic [31:0] value);
        t_walk_row row;
        row           = '0;
        row.kind      = ROW_CONFIG;
        row.cfg_sel   = cfg_sel;
        row.cfg_value = value;
        return row;
    endfunction

    initial begin : stimulus
        t_walk_row   rows [$];
        t_walk_row   row;
        logic [7:0]  r, g, b;
        logic [31:0] cfg_val;
        int          k, sent, phase, phase_len, frame_left, flip_pct;
        logic        burst;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_red          <= '0;
        i_green        <= '0;
        i_blue         <= '0;
        i_end_of_frame <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;

        model_thr       = DEF_THR;
        model_limit     = DEF_LIMIT;
        ref_side        = 1'b0;
        ref_ready       = 1'b0;
        pix_addr        = '0;
        run_sum         = '0;
        over_limit      = 1'b0;
        store_extent[0] = 0;
        store_extent[1] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first frame taken as reference, then extremes
        rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd255, 8'd0, 1'b0));
        rows.push_back(report_row(8'd0, 8'd0, 8'd255, t_frame_report'{1'b0, 32'd0, 1'b1}));
        // four mismatches under the default limit
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd255, 1'b1));
        // zero limit, top threshold: first pixel mismatches and freezes the sum
        rows.push_back(cfg_row(REG_DIFF_LIMIT, 32'd0));
        rows.push_back(cfg_row(REG_BIN_THR, 32'd255));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(report_row(8'd255, 8'd255, 8'd255, t_frame_report'{1'b1, 32'd255, 1'b0}));
        // zero threshold, full limit: gray of one is already set
        rows.push_back(cfg_row(REG_BIN_THR, 32'd0));
        rows.push_back(cfg_row(REG_DIFF_LIMIT, 32'hFFFF_FFFF));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd2, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
        rows.push_back(pix_row(8'd3, 8'd0, 8'd0, 1'b0));
        rows.push_back(pix_row(8'd0, 8'd0, 8'd9, 1'b1));
        // single pixel frame
        rows.push_back(pix_row(8'd128, 8'd128, 8'd128, 1'b1));

        for (k = 0; k < rows.size(); k++) begin
            row = rows[k];
            if (row.kind == ROW_CONFIG)
                write_register(row.cfg_sel, row.cfg_value);
            else
                push_pixel(row.red, row.green, row.blue, row.eof, row.typed, row.report);
        end

        // random phases; settings change between phases, sometimes mid-frame
        sent       = 0;
        phase      = 0;
        frame_left = 0;
        flip_pct   = 0;
        while (sent < RANDOM_PIXELS) begin
            if (phase == 0 || $urandom_range(99) < 60) begin
                case ($urandom_range(5))
                    0:       cfg_val = 32'd0;
                    1:       cfg_val = 32'd255;
                    2:       cfg_val = 32'd254;
                    default: cfg_val = $urandom_range(220, 30);
                endcase
                write_register(REG_BIN_THR, cfg_val);
            end
            if (phase == 0 || $urandom_range(99) < 60) begin
                case ($urandom_range(7))
                    0:       cfg_val = 32'd0;
                    1:       cfg_val = 32'hFFFF_FFFF;
                    2:       cfg_val = 255 * $urandom_range(8);
                    3:       cfg_val = 255 * $urandom_range(8, 1) - 1;
                    4:       cfg_val = $urandom_range(3000);
                    5:       cfg_val = 32'd200000;
                    default: cfg_val = 255 * $urandom_range(30, 1);
                endcase
                write_register(REG_DIFF_LIMIT, cfg_val);
            end

            tx_idle_pct = 28;
            rx_idle_pct = 28;
            phase_len   = $urandom_range(150, 20);
            burst       = 1'b0;
            if (phase == 2) begin
                // no idling on either side
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                phase_len   = 300;
            end else if (phase == 4) begin
                // reports back up behind a long hold-off and stall the input
                hold_requests++;
                phase_len = 60;
                burst     = 1'b1;
            end else if (phase == 6) begin
                // wait for every report before going on
                i_valid <= 1'b0;
                while (pending_reports.size() != 0) @(posedge i_clk);
            end

            for (k = 0; k < phase_len; k++) begin
                if (frame_left == 0) begin
                    if (burst)
                        frame_left = 1;
                    else if ($urandom_range(99) < 10)
                        frame_left = $urandom_range(300, 25);
                    else
                        frame_left = $urandom_range(24, 1);
                    if (frame_left > store_extent[ref_side])
                        frame_left = store_extent[ref_side];
                    case ($urandom_range(4))
                        0:       flip_pct = 0;
                        1:       flip_pct = 3;
                        2:       flip_pct = 15;
                        3:       flip_pct = 50;
                        default: flip_pct = 100;
                    endcase
                end
                if ($urandom_range(99) < 10) begin
                    r = 8'($urandom_range(255));
                    g = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                end else begin
                    pick_pixel(store_bits[ref_side][pix_addr] ^ ($urandom_range(99) < flip_pct),
                               r, g, b);
                end
                push_pixel(r, g, b, frame_left == 1, 1'b0, '0);
                frame_left--;
                sent++;
            end
            phase++;
        end

        // drain
        i_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bfdd_pkg.sv
rtl/core/bfdd_ram.sv
rtl/core/bfdd_front.sv
rtl/core/bfdd_fifo.sv
rtl/core/bfdd_back.sv
rtl/core/binary_frame_difference_detector_core.sv
test/tb_top.sv
